[src/s2dt_pkg.sv]
`timescale 1ns / 1ps

package s2dt_pkg;

    // Depth register codes.
    localparam logic [1:0] DEPTH_8BIT  = 2'd0;
    localparam logic [1:0] DEPTH_16BIT = 2'd1;

    // Characters written by the block.
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 16-bit v.
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // A 16-bit sample has at most five decimal digits.
    localparam int MAX_DIGITS = 5;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] sample_value;
        logic        line_end;
    } sample_item_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       run_last;
    } result_item_t;

    // Work held in the queue: the sample already masked to its depth.
    typedef struct packed {
        logic [15:0] value;
        logic        line_end;
    } work_item_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_CONVERT,
        BACK_DIGITS,
        BACK_SPACE,
        BACK_NEWLINE
    } back_state_t;

endpackage

[src/sample_to_decimal_text.sv]
`timescale 1ns / 1ps

// Writes each pixel sample as plain-PPM text: its decimal digits with no
// leading zeros, a space, and a newline after the last sample of a
// scanline; run_last marks the final byte of each item. A front stage takes
// items and drops them when the depth register holds an unsupported code; a
// two-entry queue feeds the back stage, which finds one digit per cycle with
// a reciprocal multiply by one tenth, then writes one byte per cycle while
// the result side takes them. For each sample the back stage reads the item
// from the queue, converts its digits, writes them most significant first,
// then the space and, at a scanline's end, the newline; it takes the next
// item from the queue only after that. The result side holds one byte;
// the depth register should be written only while the block is idle.
module sample_to_decimal_text
    import s2dt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data,
    input  logic         push,
    output logic         full,
    input  sample_item_t sample,
    output logic         empty,
    input  logic         pop,
    output result_item_t result
);

    queue_status_t q_status;
    logic          q_write;
    work_item_t    q_wr_data;
    logic          q_read;
    work_item_t    q_rd_data;

    s2dt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .q_status  (q_status),
        .q_write   (q_write),
        .q_data    (q_wr_data)
    );

    s2dt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wr_data (q_wr_data),
        .rd      (q_read),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    s2dt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .q_read   (q_read),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

[src/s2dt_front.sv]
`timescale 1ns / 1ps

module s2dt_front
    import s2dt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_data,
    input  logic          push,
    output logic          full,
    input  sample_item_t  sample,
    input  queue_status_t q_status,
    output logic          q_write,
    output work_item_t    q_data
);

    logic [1:0] depth_mode_reg;
    logic [1:0] depth_mode_next;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign full      = q_status.full;
    assign accept    = push && !q_status.full;

    always_comb
    begin
        depth_mode_next = depth_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            depth_mode_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= DEPTH_8BIT;
        end
        else
        begin
            depth_mode_reg <= depth_mode_next;
        end
    end

    // Items taken at an unsupported depth are dropped here and never queued.
    always_comb
    begin
        q_write           = 1'b0;
        q_data.line_end   = sample.line_end;
        q_data.value      = sample.sample_value;
        unique case (depth_mode_reg)
            DEPTH_8BIT:
            begin
                q_write      = accept;
                q_data.value = {8'd0, sample.sample_value[7:0]};
            end
            DEPTH_16BIT:
            begin
                q_write = accept;
            end
            default:
            begin
                q_write = 1'b0;
            end
        endcase
    end

endmodule

[src/s2dt_queue.sv]
`timescale 1ns / 1ps

module s2dt_queue
    import s2dt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  work_item_t    wr_data,
    input  logic          rd,
    output work_item_t    rd_data,
    output queue_status_t status
);

    work_item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     do_wr;
    logic                     do_rd;

    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/s2dt_back.sv]
`timescale 1ns / 1ps

module s2dt_back
    import s2dt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  work_item_t    q_data,
    output logic          q_read,
    output logic          empty,
    input  logic          pop,
    output result_item_t  result
);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [15:0]              value_reg;
    logic [15:0]              value_next;
    logic                     eol_reg;
    logic                     eol_next;
    logic [3:0]               digit_reg [MAX_DIGITS];
    logic                     digit_wr;
    logic [DIGIT_CNT_W-1:0]   count_reg;
    logic [DIGIT_CNT_W-1:0]   count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    result_item_t             out_reg;
    result_item_t             out_next;
    logic                     slot_free;
    logic [31:0]              product;
    logic [15:0]              quotient;
    logic [15:0]              times_ten;
    logic [15:0]              remainder;
    logic [DIGIT_IDX_W-1:0]   rd_idx;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign slot_free = !out_valid_reg || pop;

    // Divide by ten through the reciprocal; the remainder is the next digit.
    assign product   = value_reg * RECIP_TEN;
    assign quotient  = {3'd0, product[31:RECIP_SHIFT]};
    assign times_ten = {quotient[12:0], 3'd0} + {quotient[14:0], 1'b0};
    assign remainder = value_reg - times_ten;
    assign rd_idx    = DIGIT_IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        eol_next       = eol_reg;
        count_next     = count_reg;
        digit_wr       = 1'b0;
        q_read         = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_read     = 1'b1;
                    value_next = q_data.value;
                    eol_next   = q_data.line_end;
                    count_next = '0;
                    state_next = BACK_CONVERT;
                end
            end
            BACK_CONVERT:
            begin
                // Digits are found least significant first.
                digit_wr   = 1'b1;
                value_next = quotient;
                count_next = count_reg + 1'b1;
                if (quotient == '0)
                begin
                    state_next = BACK_DIGITS;
                end
            end
            BACK_DIGITS:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.text_byte = CHAR_ZERO + {4'd0, digit_reg[rd_idx]};
                    out_next.run_last  = 1'b0;
                    count_next         = count_reg - 1'b1;
                    if (count_reg == DIGIT_CNT_W'(1))
                    begin
                        state_next = BACK_SPACE;
                    end
                end
            end
            BACK_SPACE:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.text_byte = CHAR_SPACE;
                    out_next.run_last  = !eol_reg;
                    state_next         = eol_reg ? BACK_NEWLINE : BACK_IDLE;
                end
            end
            BACK_NEWLINE:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.text_byte = CHAR_NEWLINE;
                    out_next.run_last  = 1'b1;
                    state_next         = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        eol_reg   <= eol_next;
        out_reg   <= out_next;
        if (digit_wr)
        begin
            digit_reg[DIGIT_IDX_W'(count_reg)] <= remainder[3:0];
        end
    end

endmodule
